### design/tdrd_pkg.sv
// shared types, category codes and classification functions for the trio deletion run detector
`default_nettype none
package tdrd_pkg;

    localparam int MinSpanReset = 2;
    localparam int SpanW = 16;

    typedef enum logic [2:0] {
        CAT_NONE = 3'd0,
        CAT_A    = 3'd1,
        CAT_B    = 3'd2,
        CAT_C    = 3'd3,
        CAT_D    = 3'd4,
        CAT_E    = 3'd5,
        CAT_F    = 3'd6,
        CAT_G    = 3'd7
    } cat_t;

    localparam logic [7:0] MISSING_ALLELE = 8'hFF;

    typedef struct packed {
        logic        parent;
        logic [5:0]  run_chrom;
        logic [31:0] start_pos;
        logic [31:0] end_pos;
        logic [15:0] run_length;
        logic        last;
    } result_t;

    function automatic logic s_hom(input logic [2:0] b);
        return (b[0] == b[1]) && !b[2];
    endfunction

    function automatic logic s_mis(input logic [2:0] b);
        return b == 3'b111;
    endfunction

    function automatic logic s_het(input logic [2:0] b);
        return !b[0] && b[1];
    endfunction

    function automatic cat_t classify_snp(input logic [2:0] c, input logic [2:0] m,
                                          input logic [2:0] d);
        logic cd;
        logic dd;
        logic md;
        cd = s_hom(c) || s_mis(c);
        dd = s_hom(d) || s_mis(d);
        md = s_hom(m) || s_mis(m);
        if (s_hom(d) && d[0] == c[0] && s_hom(c) && s_hom(m) && m[0] != c[0]) return CAT_A;
        if (s_mis(d) && s_hom(c) && s_hom(m) && m[0] != c[0]) return CAT_A;
        if (s_hom(m) && m[0] == c[0] && s_hom(c) && s_hom(d) && d[0] != c[0]) return CAT_B;
        if (s_mis(m) && s_hom(c) && s_hom(d) && d[0] != c[1]) return CAT_B;
        if (s_hom(d) && s_hom(m) && d[0] == m[0] &&
            (s_het(c) || (s_hom(c) && d[0] != c[0]))) return CAT_C;
        if (s_hom(d) && s_mis(m) && d[0] != c[0] && s_hom(c)) return CAT_C;
        if (s_hom(m) && s_mis(d) && m[0] != c[0] && s_hom(c)) return CAT_C;
        if (cd && dd && md) return CAT_D;
        if (cd && s_het(d) && md) return CAT_E;
        if (cd && s_het(m) && dd) return CAT_F;
        if (s_het(c) || (s_het(m) && s_het(d))) return CAT_G;
        return CAT_NONE;
    endfunction

    function automatic cat_t classify_ms(input logic [15:0] c, input logic [15:0] m,
                                         input logic [15:0] d);
        logic ce;
        logic me;
        logic de;
        logic mm;
        logic dm;
        ce = c[7:0] == c[15:8];
        me = m[7:0] == m[15:8];
        de = d[7:0] == d[15:8];
        mm = m[7:0] == MISSING_ALLELE && m[15:8] == MISSING_ALLELE;
        dm = d[7:0] == MISSING_ALLELE && d[15:8] == MISSING_ALLELE;
        if (de && d[7:0] == c[7:0] && ce && me && m[7:0] != c[7:0]) return CAT_A;
        if (dm && ce && me && m[7:0] != c[7:0]) return CAT_A;
        if (me && m[7:0] == c[7:0] && ce && de && d[7:0] != c[7:0]) return CAT_B;
        if (mm && ce && de && d[7:0] != c[15:8]) return CAT_B;
        if (de && me && d[7:0] == m[7:0] && (!ce || d[7:0] != c[7:0])) return CAT_C;
        if (de && mm && d[7:0] != c[7:0] && ce) return CAT_C;
        if (me && dm && m[7:0] != c[7:0] && ce) return CAT_C;
        if (ce && de && me) return CAT_D;
        if (ce && !de && me) return CAT_E;
        if (ce && !me && de) return CAT_F;
        if (!ce || (!me && !de)) return CAT_G;
        return CAT_NONE;
    endfunction

endpackage
`default_nettype wire

### design/tdrd_classify.sv
// input register and genotype category classification
`default_nettype none
module tdrd_classify
    import tdrd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire logic [5:0]  chrom,
    input  wire logic [31:0] position,
    input  wire logic        classify_ok,
    input  wire logic        scan_ok,
    input  wire logic        is_microsat,
    input  wire logic [2:0]  child_bits,
    input  wire logic [2:0]  mother_bits,
    input  wire logic [2:0]  father_bits,
    input  wire logic [15:0] child_alleles,
    input  wire logic [15:0] mother_alleles,
    input  wire logic [15:0] father_alleles,
    input  wire logic        last_marker,
    output logic             item_valid,
    output cat_t             cat,
    output logic [5:0]       item_chrom,
    output logic [31:0]      item_pos,
    output logic             item_scan,
    output logic             item_last
);

    logic        valid_reg;
    logic [5:0]  chrom_reg;
    logic [31:0] pos_reg;
    logic        cls_reg;
    logic        scan_reg;
    logic        micro_reg;
    logic [2:0]  cb_reg;
    logic [2:0]  mb_reg;
    logic [2:0]  fb_reg;
    logic [15:0] ca_reg;
    logic [15:0] ma_reg;
    logic [15:0] fa_reg;
    logic        last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            chrom_reg <= chrom;
            pos_reg   <= position;
            cls_reg   <= classify_ok;
            scan_reg  <= scan_ok;
            micro_reg <= is_microsat;
            cb_reg    <= child_bits;
            mb_reg    <= mother_bits;
            fb_reg    <= father_bits;
            ca_reg    <= child_alleles;
            ma_reg    <= mother_alleles;
            fa_reg    <= father_alleles;
            last_reg  <= last_marker;
        end
    end

    always_comb
    begin
        if (!cls_reg)
        begin
            cat = CAT_NONE;
        end
        else if (micro_reg)
        begin
            cat = classify_ms(ca_reg, ma_reg, fa_reg);
        end
        else
        begin
            cat = classify_snp(cb_reg, mb_reg, fb_reg);
        end
    end

    assign item_valid = valid_reg;
    assign item_chrom = chrom_reg;
    assign item_pos   = pos_reg;
    assign item_scan  = scan_reg;
    assign item_last  = last_reg;

endmodule
`default_nettype wire

### design/tdrd_runs.sv
// run state update and result queue of two entries
`default_nettype none
module tdrd_runs
    import tdrd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [SpanW-1:0] min_span_val,
    input  wire logic             item_valid,
    input  wire cat_t             cat,
    input  wire logic [5:0]       item_chrom,
    input  wire logic [31:0]      item_pos,
    input  wire logic             item_scan,
    input  wire logic             item_last,
    output logic                  busy,
    output logic                  out_valid,
    output result_t               out_data,
    input  wire logic             out_take
);

    logic [5:0]  chrom_reg;
    logic        seen_reg;
    logic [31:0] mstart_reg;
    logic [31:0] mend_reg;
    logic [15:0] mcnt_reg;
    logic [31:0] pstart_reg;
    logic [31:0] pend_reg;
    logic [15:0] pcnt_reg;
    logic [5:0]  chrom_next;
    logic        seen_next;
    logic [31:0] mstart_next;
    logic [31:0] mend_next;
    logic [15:0] mcnt_next;
    logic [31:0] pstart_next;
    logic [31:0] pend_next;
    logic [15:0] pcnt_next;

    result_t     q_reg [2];
    logic [1:0]  qn_reg;
    result_t     q_next [2];
    logic [1:0]  qn_next;

    logic [15:0] need;
    logic        mat_grow;
    logic        pat_grow;
    logic        chg;
    logic        r0_v;
    logic        r1_v;
    logic        r2_v;
    logic        r3_v;
    logic        r4_v;
    logic        r5_v;
    result_t     r0;
    result_t     r1;
    result_t     r2;
    result_t     r3;
    result_t     r4;
    result_t     r5;
    result_t     list [6];
    logic        lv [6];
    result_t     n0;
    result_t     n1;
    logic [1:0]  cnt;
    logic [15:0] mc_a;
    logic [15:0] pc_a;

    assign need = (min_span_val == '0) ? 16'd1 : min_span_val;

    function automatic logic rep_ok(input logic [15:0] c, input logic [15:0] n);
        return (c != '0) && (c >= n);
    endfunction

    always_comb
    begin
        chrom_next  = chrom_reg;
        seen_next   = seen_reg;
        mstart_next = mstart_reg;
        mend_next   = mend_reg;
        mcnt_next   = mcnt_reg;
        pstart_next = pstart_reg;
        pend_next   = pend_reg;
        pcnt_next   = pcnt_reg;
        chg         = item_scan && seen_reg && (chrom_reg != item_chrom);
        mat_grow    = (cat == CAT_A) || (cat == CAT_D) ||
                      ((cat == CAT_E) && ((chg ? 16'd0 : pcnt_reg) == '0));
        pat_grow    = !mat_grow && ((cat == CAT_B) ||
                      ((cat == CAT_F) && ((chg ? 16'd0 : mcnt_reg) == '0)));
        r0 = '{1'b0, chrom_reg, mstart_reg, mend_reg, mcnt_reg, 1'b0};
        r1 = '{1'b1, chrom_reg, pstart_reg, pend_reg, pcnt_reg, 1'b0};
        r0_v = chg && rep_ok(mcnt_reg, need);
        r1_v = chg && rep_ok(pcnt_reg, need);
        mc_a = chg ? 16'd0 : mcnt_reg;
        pc_a = chg ? 16'd0 : pcnt_reg;
        if (chg)
        begin
            mstart_next = '0;
            mend_next   = '0;
            mcnt_next   = '0;
            pstart_next = '0;
            pend_next   = '0;
            pcnt_next   = '0;
        end
        r2 = '{1'b0, item_chrom, mstart_reg, mend_reg, mcnt_reg, 1'b0};
        r3 = '{1'b1, item_chrom, pstart_reg, pend_reg, pcnt_reg, 1'b0};
        r2_v = 1'b0;
        r3_v = 1'b0;
        if (item_scan)
        begin
            chrom_next = item_chrom;
            seen_next  = 1'b1;
            if (mat_grow)
            begin
                if (mc_a == '0)
                begin
                    mstart_next = item_pos;
                end
                mend_next = item_pos;
                mcnt_next = (mc_a == 16'hFFFF) ? mc_a : mc_a + 16'd1;
                r3_v = rep_ok(pc_a, need);
                pstart_next = '0;
                pend_next   = '0;
                pcnt_next   = '0;
            end
            else if (pat_grow)
            begin
                if (pc_a == '0)
                begin
                    pstart_next = item_pos;
                end
                pend_next = item_pos;
                pcnt_next = (pc_a == 16'hFFFF) ? pc_a : pc_a + 16'd1;
                r2_v = rep_ok(mc_a, need);
                mstart_next = '0;
                mend_next   = '0;
                mcnt_next   = '0;
            end
            else
            begin
                r2_v = rep_ok(mc_a, need);
                r3_v = rep_ok(pc_a, need);
                mstart_next = '0;
                mend_next   = '0;
                mcnt_next   = '0;
                pstart_next = '0;
                pend_next   = '0;
                pcnt_next   = '0;
            end
        end
        r4 = '{1'b1, chrom_next, pstart_next, pend_next, pcnt_next, 1'b0};
        r5 = '{1'b0, chrom_next, mstart_next, mend_next, mcnt_next, 1'b0};
        r4_v = item_last && rep_ok(pcnt_next, need);
        r5_v = item_last && rep_ok(mcnt_next, need);
        if (item_last)
        begin
            chrom_next  = '0;
            seen_next   = 1'b0;
            mstart_next = '0;
            mend_next   = '0;
            mcnt_next   = '0;
            pstart_next = '0;
            pend_next   = '0;
            pcnt_next   = '0;
        end
        list[0] = r0;
        list[1] = r1;
        list[2] = r2;
        list[3] = r3;
        list[4] = r4;
        list[5] = r5;
        lv[0] = r0_v;
        lv[1] = r1_v;
        lv[2] = r2_v;
        lv[3] = r3_v;
        lv[4] = r4_v;
        lv[5] = r5_v;
        n0  = r0;
        n1  = r0;
        cnt = 2'd0;
        for (int i = 0; i < 6; i++)
        begin
            if (lv[i] && cnt == 2'd0)
            begin
                n0  = list[i];
                cnt = 2'd1;
            end
            else if (lv[i] && cnt == 2'd1)
            begin
                n1  = list[i];
                cnt = 2'd2;
            end
        end
        if (cnt == 2'd1)
        begin
            n0.last = 1'b1;
        end
        n1.last = 1'b1;
    end

    always_comb
    begin
        q_next[0] = q_reg[0];
        q_next[1] = q_reg[1];
        qn_next   = qn_reg;
        if (out_take)
        begin
            q_next[0] = q_reg[1];
            qn_next   = qn_reg - 2'd1;
        end
        if (item_valid)
        begin
            if (qn_next == 2'd0)
            begin
                q_next[0] = n0;
                q_next[1] = n1;
            end
            else
            begin
                q_next[1] = n0;
            end
            qn_next = qn_next + cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chrom_reg  <= '0;
            seen_reg   <= 1'b0;
            mstart_reg <= '0;
            mend_reg   <= '0;
            mcnt_reg   <= '0;
            pstart_reg <= '0;
            pend_reg   <= '0;
            pcnt_reg   <= '0;
            qn_reg     <= '0;
        end
        else
        begin
            if (item_valid)
            begin
                chrom_reg  <= chrom_next;
                seen_reg   <= seen_next;
                mstart_reg <= mstart_next;
                mend_reg   <= mend_next;
                mcnt_reg   <= mcnt_next;
                pstart_reg <= pstart_next;
                pend_reg   <= pend_next;
                pcnt_reg   <= pcnt_next;
            end
            qn_reg <= qn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
    end

    // a stage item may add two results, so accept only when the queue ends this cycle empty
    assign busy      = qn_next != 2'd0;
    assign out_valid = qn_reg != 2'd0;
    assign out_data  = q_reg[0];

endmodule
`default_nettype wire

### design/trio_deletion_run_detector_top.sv
// top level of the trio deletion run detector
//
// one marker of a parent-child trio enters per transaction on the input channel
// (valid/stall); maternal and paternal deletion runs that close with at least
// min_span markers leave as result transactions on the output channel
// (valid/stall), at most two per marker, the final one flagged by last
// min_span is written through its own valid/ready channel; the user must write it
// only while the block is idle, the block itself does not enforce this
// a marker is registered, then classified, and its run update plus results are
// written into a two-entry result queue whose head drives the output channel
// throughput: one marker per cycle while the receiver keeps up and markers close
// no runs; a marker is taken only while the result queue can hold whatever the
// marker in flight and the new one may produce, so reported runs stall the input
// until the queue drains; when the receiver stalls, results stay in the queue,
// stall rises on the input side and nothing is lost
// reset clears all runs, the queue and sets min_span to MIN_SPAN_RESET (default 2)
`default_nettype none
module trio_deletion_run_detector_top
    import tdrd_pkg::*;
#(
    parameter int MIN_SPAN_RESET = MinSpanReset
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [5:0]       chrom,
    input  wire logic [31:0]      position,
    input  wire logic             classify_ok,
    input  wire logic             scan_ok,
    input  wire logic             is_microsat,
    input  wire logic [2:0]       child_bits,
    input  wire logic [2:0]       mother_bits,
    input  wire logic [2:0]       father_bits,
    input  wire logic [15:0]      child_alleles,
    input  wire logic [15:0]      mother_alleles,
    input  wire logic [15:0]      father_alleles,
    input  wire logic             last_marker,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic                  parent,
    output logic [5:0]            run_chrom,
    output logic [31:0]           start_pos,
    output logic [31:0]           end_pos,
    output logic [15:0]           run_length,
    output logic                  last,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [SpanW-1:0] cfg_data
);

    logic [SpanW-1:0] min_span_reg;
    logic             load;
    logic             item_valid;
    cat_t             cat;
    logic [5:0]       item_chrom;
    logic [31:0]      item_pos;
    logic             item_scan;
    logic             item_last;
    logic             busy;
    result_t          res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_span_reg <= SpanW'(MIN_SPAN_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            min_span_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;
    assign in_stall  = busy;
    assign load      = in_valid && !in_stall;

    tdrd_classify u_classify (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (load),
        .chrom          (chrom),
        .position       (position),
        .classify_ok    (classify_ok),
        .scan_ok        (scan_ok),
        .is_microsat    (is_microsat),
        .child_bits     (child_bits),
        .mother_bits    (mother_bits),
        .father_bits    (father_bits),
        .child_alleles  (child_alleles),
        .mother_alleles (mother_alleles),
        .father_alleles (father_alleles),
        .last_marker    (last_marker),
        .item_valid     (item_valid),
        .cat            (cat),
        .item_chrom     (item_chrom),
        .item_pos       (item_pos),
        .item_scan      (item_scan),
        .item_last      (item_last)
    );

    tdrd_runs u_runs (
        .clk          (clk),
        .rst_n        (rst_n),
        .min_span_val (min_span_reg),
        .item_valid   (item_valid),
        .cat          (cat),
        .item_chrom   (item_chrom),
        .item_pos     (item_pos),
        .item_scan    (item_scan),
        .item_last    (item_last),
        .busy         (busy),
        .out_valid    (out_valid),
        .out_data     (res),
        .out_take     (out_valid && !out_stall)
    );

    assign parent     = res.parent;
    assign run_chrom  = res.run_chrom;
    assign start_pos  = res.start_pos;
    assign end_pos    = res.end_pos;
    assign run_length = res.run_length;
    assign last       = res.last;

endmodule
`default_nettype wire

### design/tdrd_checker.sv
// port-level checker for the trio deletion run detector and its bind
`default_nettype none
module tdrd_port_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_stall,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire logic last,
    input wire logic parent
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(last) && $stable(parent))
        else $error("stalled result changed");

    a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall && !last |-> in_stall)
        else $error("input taken while two results wait");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result after reset");

    a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid)
        else $error("result pair broken");

endmodule

bind trio_deletion_run_detector_top tdrd_port_checker u_tdrd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .last      (last),
    .parent    (parent)
);
`default_nettype wire
